/* src/dpd_pkg.sv */
// Shared types and constants for the pixel deprojection pipeline.
package dpd_pkg;

  // Pipeline stages in each section, and in total.
  localparam int NORM_STAGES  = 2;
  localparam int DIST_STAGES  = 10;
  localparam int SCALE_STAGES = 2;
  localparam int STAGES       = NORM_STAGES + DIST_STAGES + SCALE_STAGES;

  // Normalized coordinate (Q.20, clamped) and undistorted coordinate widths.
  localparam int XN_W = 23;
  localparam int U_W  = 46;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PRINCIPAL_POINT = 3'd0,
    REG_INV_FOCAL_X     = 3'd1,
    REG_INV_FOCAL_Y     = 3'd2,
    REG_RADIAL_K1       = 3'd3,
    REG_RADIAL_K2       = 3'd4,
    REG_RADIAL_K3       = 3'd5,
    REG_TANGENTIAL_P1   = 3'd6,
    REG_TANGENTIAL_P2   = 3'd7
  } cfg_reg_t;

  // Data that rides along with each item.
  typedef struct packed {
    logic [15:0] depth;
    logic        sat;
  } side_t;

  // Per-stage load enables and valid bits.
  typedef struct packed {
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] vld;
  } pipe_ctl_t;

endpackage

/* src/dpd_ctrl.sv */
// Valid bits and per-stage load enables for the deprojection pipeline.
module dpd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output dpd_pkg::pipe_ctl_t ctl
);
  import dpd_pkg::*;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] ready;

  // A stage may load when it or any stage after it is empty, or out_stall is low.
  always_comb begin
    logic [STAGES-1:0] low;
    for (int i = 0; i < STAGES; i++) begin
      low      = (STAGES'(1) << i) - STAGES'(1);
      ready[i] = !out_stall || !(&(vld | low));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[0]) vld[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (ready[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign ctl.en    = ready;
  assign ctl.vld   = vld;
  assign in_stall  = !ready[0];
  assign out_valid = vld[STAGES-1];

endmodule

/* src/dpd_norm.sv */
// Principal point offset, reciprocal focal scaling, rounding and clamp to Q.20.
module dpd_norm #(
  parameter int PIXEL_FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic [dpd_pkg::NORM_STAGES-1:0]  en,
  input  logic [19:0]                      pixel_x,
  input  logic [19:0]                      pixel_y,
  input  logic [15:0]                      depth,
  input  logic [19:0]                      pp_x,
  input  logic [19:0]                      pp_y,
  input  logic [31:0]                      inv_fx,
  input  logic [31:0]                      inv_fy,
  output logic signed [dpd_pkg::XN_W-1:0]  xn,
  output logic signed [dpd_pkg::XN_W-1:0]  yn,
  output dpd_pkg::side_t                   side
);
  import dpd_pkg::*;

  localparam int NS = PIXEL_FRAC_BITS + 12;
  localparam logic signed [53:0] HALF    = 54'sd1 <<< (NS - 1);
  localparam logic signed [53:0] NORM_HI = 54'sd4194303;
  localparam logic signed [53:0] NORM_LO = -54'sd4194304;

  logic signed [20:0] dx, dy;
  logic signed [53:0] mx, my;
  logic [15:0]        d0;
  logic signed [53:0] sx, sy;
  logic signed [XN_W-1:0] cx, cy;
  logic               clip;

  assign dx = $signed({1'b0, pixel_x}) - $signed({1'b0, pp_x});
  assign dy = $signed({1'b0, pixel_y}) - $signed({1'b0, pp_y});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mx <= dx * $signed({1'b0, inv_fx});
      my <= dy * $signed({1'b0, inv_fy});
      d0 <= depth;
    end
  end

  always_comb begin
    sx   = (mx + HALF) >>> NS;
    sy   = (my + HALF) >>> NS;
    clip = 1'b0;
    if (sx > NORM_HI) begin
      cx = XN_W'(NORM_HI);
      clip = 1'b1;
    end else if (sx < NORM_LO) begin
      cx = XN_W'(NORM_LO);
      clip = 1'b1;
    end else begin
      cx = XN_W'(sx);
    end
    if (sy > NORM_HI) begin
      cy = XN_W'(NORM_HI);
      clip = 1'b1;
    end else if (sy < NORM_LO) begin
      cy = XN_W'(NORM_LO);
      clip = 1'b1;
    end else begin
      cy = XN_W'(sy);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xn         <= cx;
      yn         <= cy;
      side.depth <= d0;
      side.sat   <= clip;
    end
  end

endmodule

/* src/dpd_distort.sv */
// Inverse Brown-Conrady correction: radial polynomial and tangential terms.
module dpd_distort #(
  parameter int DISTORTION_ON = 1
) (
  input  logic                             clk,
  input  logic [dpd_pkg::DIST_STAGES-1:0]  en,
  input  logic signed [dpd_pkg::XN_W-1:0]  xn,
  input  logic signed [dpd_pkg::XN_W-1:0]  yn,
  input  dpd_pkg::side_t                   side_in,
  input  logic signed [23:0]               k1,
  input  logic signed [23:0]               k2,
  input  logic signed [23:0]               k3,
  input  logic signed [23:0]               p1,
  input  logic signed [23:0]               p2,
  output logic signed [dpd_pkg::U_W-1:0]   ux,
  output logic signed [dpd_pkg::U_W-1:0]   uy,
  output dpd_pkg::side_t                   side_out
);
  import dpd_pkg::*;

  side_t side_q [DIST_STAGES];

  always_ff @(posedge clk) begin
    if (en[0]) side_q[0] <= side_in;
    for (int k = 1; k < DIST_STAGES; k++) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
  end

  assign side_out = side_q[DIST_STAGES-1];

  if (DISTORTION_ON != 0) begin : g_dist
    // xn/yn are needed again at the f multiply; tangential sums at the last add.
    logic signed [XN_W-1:0] xn_q [8];
    logic signed [XN_W-1:0] yn_q [8];
    logic signed [45:0] xx, yy, xyp;
    logic signed [26:0] r2_1, xy2;
    logic signed [27:0] ax, ay;
    logic signed [53:0] r4p;
    logic signed [50:0] k1p, tx1p, ty1p;
    logic signed [51:0] tx2p, ty2p;
    logic signed [26:0] r2_2, r2_3;
    logic signed [31:0] r4;
    logic signed [30:0] k1t, k1t_4;
    logic signed [32:0] tx3, ty3;
    logic signed [32:0] txd [5];
    logic signed [32:0] tyd [5];
    logic signed [58:0] r6p;
    logic signed [55:0] k2p;
    logic signed [36:0] r6;
    logic signed [35:0] acc, acc_6;
    logic signed [60:0] k3p;
    logic signed [41:0] f;
    logic signed [64:0] xfp, yfp;

    logic signed [45:0] xx_r, yy_r, xy_r;
    logic signed [25:0] x2, y2, xy;
    logic signed [26:0] r2c;
    logic signed [53:0] r4_r;
    logic signed [50:0] k1_r, tx1_r, ty1_r;
    logic signed [51:0] tx2_r, ty2_r;
    logic signed [58:0] r6_r;
    logic signed [55:0] k2_r;
    logic signed [60:0] k3_r;
    logic signed [64:0] xf_r, yf_r;

    always_comb begin
      xx_r  = xx + 46'sd524288;
      yy_r  = yy + 46'sd524288;
      xy_r  = xyp + 46'sd524288;
      x2    = $signed(xx_r[45:20]);
      y2    = $signed(yy_r[45:20]);
      xy    = $signed(xy_r[45:20]);
      r2c   = 27'(x2) + 27'(y2);
      r4_r  = r4p + 54'sd524288;
      k1_r  = k1p + 51'sd524288;
      tx1_r = tx1p + 51'sd524288;
      ty1_r = ty1p + 51'sd524288;
      tx2_r = tx2p + 52'sd524288;
      ty2_r = ty2p + 52'sd524288;
      r6_r  = r6p + 59'sd524288;
      k2_r  = k2p + 56'sd524288;
      k3_r  = k3p + 61'sd524288;
      xf_r  = xfp + 65'sd524288;
      yf_r  = yfp + 65'sd524288;
    end

    always_ff @(posedge clk) begin
      if (en[0]) begin
        xx  <= xn * xn;
        yy  <= yn * yn;
        xyp <= xn * yn;
        xn_q[0] <= xn;
        yn_q[0] <= yn;
      end
      for (int k = 1; k < 8; k++) begin
        if (en[k]) begin
          xn_q[k] <= xn_q[k-1];
          yn_q[k] <= yn_q[k-1];
        end
      end
      if (en[1]) begin
        r2_1 <= r2c;
        ax   <= 28'(r2c) + 28'({x2, 1'b0});
        ay   <= 28'(r2c) + 28'({y2, 1'b0});
        xy2  <= {xy, 1'b0};
      end
      if (en[2]) begin
        r4p  <= r2_1 * r2_1;
        k1p  <= k1 * r2_1;
        tx1p <= p1 * xy2;
        tx2p <= p2 * ax;
        ty1p <= p2 * xy2;
        ty2p <= p1 * ay;
        r2_2 <= r2_1;
      end
      if (en[3]) begin
        r4   <= $signed(r4_r[51:20]);
        k1t  <= $signed(k1_r[50:20]);
        tx3  <= 33'($signed(tx1_r[50:20])) + 33'($signed(tx2_r[51:20]));
        ty3  <= 33'($signed(ty1_r[50:20])) + 33'($signed(ty2_r[51:20]));
        r2_3 <= r2_2;
      end
      if (en[4]) begin
        r6p    <= r4 * r2_3;
        k2p    <= k2 * r4;
        k1t_4  <= k1t;
        txd[0] <= tx3;
        tyd[0] <= ty3;
      end
      for (int k = 1; k < 5; k++) begin
        if (en[4+k]) begin
          txd[k] <= txd[k-1];
          tyd[k] <= tyd[k-1];
        end
      end
      if (en[5]) begin
        r6  <= $signed(r6_r[56:20]);
        acc <= 36'(k1t_4) + $signed(k2_r[55:20]);
      end
      if (en[6]) begin
        k3p   <= k3 * r6;
        acc_6 <= acc;
      end
      if (en[7]) begin
        f <= 42'sd1048576 + 42'(acc_6) + 42'($signed(k3_r[60:20]));
      end
      if (en[8]) begin
        xfp <= xn_q[7] * f;
        yfp <= yn_q[7] * f;
      end
      if (en[9]) begin
        ux <= U_W'($signed(xf_r[64:20])) + U_W'(txd[4]);
        uy <= U_W'($signed(yf_r[64:20])) + U_W'(tyd[4]);
      end
    end
  end else begin : g_bypass
    // No correction: the normalized point passes with the same latency.
    logic signed [U_W-1:0] ux_q [DIST_STAGES];
    logic signed [U_W-1:0] uy_q [DIST_STAGES];

    always_ff @(posedge clk) begin
      if (en[0]) begin
        ux_q[0] <= U_W'(xn);
        uy_q[0] <= U_W'(yn);
      end
      for (int k = 1; k < DIST_STAGES; k++) begin
        if (en[k]) begin
          ux_q[k] <= ux_q[k-1];
          uy_q[k] <= uy_q[k-1];
        end
      end
    end

    assign ux = ux_q[DIST_STAGES-1];
    assign uy = uy_q[DIST_STAGES-1];
  end

endmodule

/* src/dpd_scale.sv */
// Depth scaling, rounding and saturation of the output point.
module dpd_scale (
  input  logic                             clk,
  input  logic [dpd_pkg::SCALE_STAGES-1:0] en,
  input  logic signed [dpd_pkg::U_W-1:0]   ux,
  input  logic signed [dpd_pkg::U_W-1:0]   uy,
  input  dpd_pkg::side_t                   side_in,
  output logic signed [18:0]               point_x,
  output logic signed [18:0]               point_y,
  output logic [15:0]                      point_z,
  output logic                             saturated
);
  import dpd_pkg::*;

  localparam logic signed [62:0] OUT_HI = 63'sd262143;
  localparam logic signed [62:0] OUT_LO = -63'sd262144;

  logic signed [62:0] mx, my;
  side_t              side0;
  logic signed [62:0] sx, sy;
  logic signed [18:0] cx, cy;
  logic               clip;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mx    <= ux * $signed({1'b0, side_in.depth});
      my    <= uy * $signed({1'b0, side_in.depth});
      side0 <= side_in;
    end
  end

  always_comb begin
    sx   = (mx + 63'sd524288) >>> 20;
    sy   = (my + 63'sd524288) >>> 20;
    clip = side0.sat;
    if (sx > OUT_HI) begin
      cx = 19'(OUT_HI);
      clip = 1'b1;
    end else if (sx < OUT_LO) begin
      cx = 19'(OUT_LO);
      clip = 1'b1;
    end else begin
      cx = 19'(sx);
    end
    if (sy > OUT_HI) begin
      cy = 19'(OUT_HI);
      clip = 1'b1;
    end else if (sy < OUT_LO) begin
      cy = 19'(OUT_LO);
      clip = 1'b1;
    end else begin
      cy = 19'(sy);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      point_x   <= cx;
      point_y   <= cy;
      point_z   <= side0.depth;
      saturated <= clip;
    end
  end

endmodule

/* src/pixel_deprojection_with_distortion.sv */
// Top level: pixel to 3D point deprojection with inverse lens distortion.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | pixel_x, pixel_y (Q12.8), depth
//  out      | out_valid / out_stall| point_x, point_y, point_z, saturated
//  cfg      | cfg_write            | cfg_index, cfg_data (write only, no wait)
//
// One item per clock sustained while out_stall is low; 14 register stages
// (2 normalize, 10 distortion, 2 depth scale), the last one driving out_valid.
// Synchronous active-high rst clears the stage valid bits and config registers.
// A stage loads whenever it is empty or the stages after it move, so bubbles
// close up under out_stall; in_stall rises only with all 14 stages full.
module pixel_deprojection_with_distortion #(
  parameter int DISTORTION_ON   = 1,
  parameter int PIXEL_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        pixel_x,
  input  logic [19:0]        pixel_y,
  input  logic [15:0]        depth,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [18:0] point_x,
  output logic signed [18:0] point_y,
  output logic [15:0]        point_z,
  output logic               saturated,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [39:0]        cfg_data
);
  import dpd_pkg::*;

  // Configuration registers; the user writes them only while the pipeline is empty (not enforced).
  logic [19:0]        pp_x, pp_y;
  logic [31:0]        inv_fx, inv_fy;
  logic signed [23:0] k1, k2, k3, p1, p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_x   <= '0;
      pp_y   <= '0;
      inv_fx <= '0;
      inv_fy <= '0;
      k1     <= '0;
      k2     <= '0;
      k3     <= '0;
      p1     <= '0;
      p2     <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRINCIPAL_POINT: begin
          pp_x <= cfg_data[19:0];
          pp_y <= cfg_data[39:20];
        end
        REG_INV_FOCAL_X:   inv_fx <= cfg_data[31:0];
        REG_INV_FOCAL_Y:   inv_fy <= cfg_data[31:0];
        REG_RADIAL_K1:     k1 <= $signed(cfg_data[23:0]);
        REG_RADIAL_K2:     k2 <= $signed(cfg_data[23:0]);
        REG_RADIAL_K3:     k3 <= $signed(cfg_data[23:0]);
        REG_TANGENTIAL_P1: p1 <= $signed(cfg_data[23:0]);
        REG_TANGENTIAL_P2: p2 <= $signed(cfg_data[23:0]);
        default: ;
      endcase
    end
  end

  // Stage control: valid bits and load enables for all sections.
  pipe_ctl_t ctl;

  dpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  // Normalize: offset from principal point, scale by reciprocal focal length.
  logic signed [XN_W-1:0] xn, yn;
  side_t                  side_n;

  dpd_norm #(
    .PIXEL_FRAC_BITS (PIXEL_FRAC_BITS)
  ) u_norm (
    .clk     (clk),
    .en      (ctl.en[NORM_STAGES-1:0]),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .depth   (depth),
    .pp_x    (pp_x),
    .pp_y    (pp_y),
    .inv_fx  (inv_fx),
    .inv_fy  (inv_fy),
    .xn      (xn),
    .yn      (yn),
    .side    (side_n)
  );

  // Distortion: radial factor f(r2) and tangential terms.
  logic signed [U_W-1:0] ux, uy;
  side_t                 side_d;

  dpd_distort #(
    .DISTORTION_ON (DISTORTION_ON)
  ) u_distort (
    .clk      (clk),
    .en       (ctl.en[NORM_STAGES+DIST_STAGES-1:NORM_STAGES]),
    .xn       (xn),
    .yn       (yn),
    .side_in  (side_n),
    .k1       (k1),
    .k2       (k2),
    .k3       (k3),
    .p1       (p1),
    .p2       (p2),
    .ux       (ux),
    .uy       (uy),
    .side_out (side_d)
  );

  // Depth scale and output saturation; the last stage is the output register.
  dpd_scale u_scale (
    .clk       (clk),
    .en        (ctl.en[STAGES-1:NORM_STAGES+DIST_STAGES]),
    .ux        (ux),
    .uy        (uy),
    .side_in   (side_d),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .saturated (saturated)
  );

`ifndef SYNTHESIS
  // The input side stalls only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&ctl.vld))
    else $error("input stalled with an empty stage");

  // An accepted item lands in the first stage.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> ctl.vld[0])
    else $error("accepted item lost at first stage");

  // Occupancy grows by one when an item enters and none leaves.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !(out_valid && !out_stall)) |=>
      ($countones(ctl.vld) == $past($countones(ctl.vld)) + 1))
    else $error("pipeline occupancy mismatch");
`endif

endmodule

/* dv/pixel_deprojection_with_distortion_test.sv */
// Self-checking testbench for the pixel deprojection pipeline with lens distortion.
module pixel_deprojection_with_distortion_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dpd_pkg::*;

  localparam int DISTORTION_ON   = 1;
  localparam int PIXEL_FRAC_BITS = 8;

  // Fixed-point layout: normalized coordinates are Q.20.
  localparam int     FRAC       = 20;
  localparam int     NORM_SHIFT = PIXEL_FRAC_BITS + 12;
  localparam longint NORM_HI    = 4194303;
  localparam longint NORM_LO    = -4194304;
  localparam longint OUT_HI     = 262143;
  localparam longint OUT_LO     = -262144;

  localparam logic [19:0] PX_MAX = 20'hFFFFF;
  localparam logic [15:0] D_MAX  = 16'hFFFF;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 168;

  // Receiver stall patterns, chosen at random by the receiver.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  typedef struct {
    logic [19:0] px;
    logic [19:0] py;
    logic [15:0] d;
  } pixel_item_t;

  typedef struct {
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic [15:0]        z;
    logic               sat;
  } point_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [19:0]        pixel_x   = '0;
  logic [19:0]        pixel_y   = '0;
  logic [15:0]        depth     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [18:0] point_x;
  logic signed [18:0] point_y;
  logic [15:0]        point_z;
  logic               saturated;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [39:0]        cfg_data  = '0;

  pixel_deprojection_with_distortion #(
    .DISTORTION_ON   (DISTORTION_ON),
    .PIXEL_FRAC_BITS (PIXEL_FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .depth     (depth),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .saturated (saturated),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the camera registers, kept in step with every write
  // ---------------------------------------------------------------------------
  logic [39:0]        cam_pp  = '0;
  logic [31:0]        cam_ifx = '0;
  logic [31:0]        cam_ify = '0;
  logic signed [23:0] cam_k1  = '0;
  logic signed [23:0] cam_k2  = '0;
  logic signed [23:0] cam_k3  = '0;
  logic signed [23:0] cam_p1  = '0;
  logic signed [23:0] cam_p2  = '0;

  pixel_item_t pixels_to_send[$];
  point_t      points_due[$];

  int items_queued  = 0;
  int results_seen  = 0;
  int failures      = 0;
  int clipped_seen  = 0;
  int holds_done    = 0;
  int settings_used = 1;

  // Round half up: floor((v + 2^(s-1)) / 2^s); >>> on a signed value floors.
  function automatic longint round_shift(longint v, int s);
    longint one;
    one = 1;
    return (v + (one <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi, inout logic flag);
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Expected 3D point for one pixel under the current camera settings.
  function automatic point_t project_pixel(logic [19:0] px, logic [19:0] py, logic [15:0] d);
    longint xn, yn, x2, y2, xy, r2, r4, r6, f, ux, uy, ox, oy;
    logic   sat;
    point_t p;
    sat = 1'b0;
    xn = round_shift((longint'(px) - longint'(cam_pp[19:0])) * longint'(cam_ifx), NORM_SHIFT);
    yn = round_shift((longint'(py) - longint'(cam_pp[39:20])) * longint'(cam_ify), NORM_SHIFT);
    // Clamp to [-4.0, just under +4.0] so nothing downstream can overflow.
    xn = clip(xn, NORM_LO, NORM_HI, sat);
    yn = clip(yn, NORM_LO, NORM_HI, sat);
    ux = xn;
    uy = yn;
    if (DISTORTION_ON != 0) begin
      x2 = round_shift(xn * xn, FRAC);
      y2 = round_shift(yn * yn, FRAC);
      xy = round_shift(xn * yn, FRAC);
      r2 = x2 + y2;
      r4 = round_shift(r2 * r2, FRAC);
      r6 = round_shift(r4 * r2, FRAC);
      // radial factor 1 + k1 r^2 + k2 r^4 + k3 r^6
      f  = (longint'(1) <<< FRAC) + round_shift(longint'(cam_k1) * r2, FRAC)
         + round_shift(longint'(cam_k2) * r4, FRAC) + round_shift(longint'(cam_k3) * r6, FRAC);
      ux = round_shift(xn * f, FRAC) + round_shift(2 * longint'(cam_p1) * xy, FRAC)
         + round_shift(longint'(cam_p2) * (r2 + 2 * x2), FRAC);
      uy = round_shift(yn * f, FRAC) + round_shift(2 * longint'(cam_p2) * xy, FRAC)
         + round_shift(longint'(cam_p1) * (r2 + 2 * y2), FRAC);
    end
    ox = clip(round_shift(longint'(d) * ux, FRAC), OUT_LO, OUT_HI, sat);
    oy = clip(round_shift(longint'(d) * uy, FRAC), OUT_LO, OUT_HI, sat);
    p.x   = ox[18:0];
    p.y   = oy[18:0];
    p.z   = d;
    p.sat = sat;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes: one per clock, only while the pipeline is empty
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_t idx, logic [39:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PRINCIPAL_POINT: cam_pp  = val;
      REG_INV_FOCAL_X:     cam_ifx = val[31:0];
      REG_INV_FOCAL_Y:     cam_ify = val[31:0];
      REG_RADIAL_K1:       cam_k1  = val[23:0];
      REG_RADIAL_K2:       cam_k2  = val[23:0];
      REG_RADIAL_K3:       cam_k3  = val[23:0];
      REG_TANGENTIAL_P1:   cam_p1  = val[23:0];
      REG_TANGENTIAL_P2:   cam_p2  = val[23:0];
      default: ;
    endcase
  endtask

  task automatic load_camera(logic [39:0] pp, logic [39:0] ifx, logic [39:0] ify,
                             logic [39:0] k1, logic [39:0] k2, logic [39:0] k3,
                             logic [39:0] p1, logic [39:0] p2);
    write_reg(REG_PRINCIPAL_POINT, pp);
    write_reg(REG_INV_FOCAL_X, ifx);
    write_reg(REG_INV_FOCAL_Y, ify);
    write_reg(REG_RADIAL_K1, k1);
    write_reg(REG_RADIAL_K2, k2);
    write_reg(REG_RADIAL_K3, k3);
    write_reg(REG_TANGENTIAL_P1, p1);
    write_reg(REG_TANGENTIAL_P2, p2);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic add_pixel(logic [19:0] px, logic [19:0] py, logic [15:0] d);
    pixel_item_t it;
    it.px = px;
    it.py = py;
    it.d  = d;
    pixels_to_send.insert(pixels_to_send.size(), it);
    items_queued++;
  endtask

  // One result per item, so the pipe is empty once every result is back.
  task automatic wait_drained();
    while (results_seen < items_queued) @(posedge clk);
  endtask

  // Coefficient: mostly within +-lim, sometimes the signed extremes or zero.
  // Upper data bits are junk; only the low 24 bits belong to the register.
  function automatic logic [39:0] pick_coeff(int lim);
    logic [23:0] c;
    case ($urandom_range(0, 9))
      0:       c = 24'h7FFFFF;
      1:       c = 24'h800000;
      2:       c = '0;
      default: c = 24'(int'($urandom_range(0, 2 * lim)) - lim);
    endcase
    return {16'($urandom), c};
  endfunction

  function automatic logic [39:0] pick_focal(bit wild);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      default: v = wild ? 32'($urandom) : 32'(64'h1_0000_0000 / $urandom_range(150, 2000));
    endcase
    return {8'($urandom), v};
  endfunction

  // Coordinate: image-sized, full range, edges, or close to the principal point.
  function automatic logic [19:0] pick_coord(logic [19:0] center, int span);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PX_MAX;
      2, 3, 4: return 20'($urandom);
      5, 6:    return center + 20'($urandom_range(0, 8192)) - 20'd4096;
      default: return 20'($urandom_range(0, span));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length from the item queue, random gaps between
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : sender
    pixel_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        points_due.insert(points_due.size(), project_pixel(pixel_x, pixel_y, depth));
      end
      // payload holds while stalled
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixels_to_send.size() != 0) begin
          nxt = pixels_to_send.pop_front();
          pixel_x  <= nxt.px;
          pixel_y  <= nxt.py;
          depth    <= nxt.d;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 20);
            gap_left   = $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks results in order and stalls on its own pattern.
  // Every 300 results it holds off for a long stretch so the pipe backs up.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode      = RX_FREE;
  int       rx_cycle     = 0;
  int       hold_left    = 0;
  int       last_hold_at = -1;

  always @(posedge clk) begin : receiver
    point_t want;
    logic   stall_next;
    if (!rst) begin
      rx_cycle++;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (saturated) clipped_seen++;
        if (points_due.size() == 0) begin
          $error("result with no item pending: point_x %0d point_y %0d", point_x, point_y);
          failures++;
        end else begin
          want = points_due.pop_front();
          if (point_x !== want.x) begin
            $error("point_x mismatch: expected %0d, actual %0d", want.x, point_x);
            failures++;
          end
          if (point_y !== want.y) begin
            $error("point_y mismatch: expected %0d, actual %0d", want.y, point_y);
            failures++;
          end
          if (point_z !== want.z) begin
            $error("point_z mismatch: expected %0d, actual %0d", want.z, point_z);
            failures++;
          end
          if (saturated !== want.sat) begin
            $error("saturated mismatch: expected %0b, actual %0b", want.sat, saturated);
            failures++;
          end
        end
      end
      if (rx_cycle % 128 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
      end else if (results_seen % 300 == 150 && results_seen != last_hold_at) begin
        last_hold_at = results_seen;
        hold_left    = $urandom_range(60, 90);
        holds_done++;
      end
      case (rx_mode)
        RX_FREE:     stall_next = 1'b0;
        RX_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
        RX_HEAVY:    stall_next = ($urandom_range(0, 9) < 6);
        RX_PERIODIC: stall_next = (rx_cycle % 5 < 2);
        default:     stall_next = 1'b0;
      endcase
      out_stall <= (hold_left > 0) || stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed phases, then random camera settings
  // ---------------------------------------------------------------------------
  initial begin
    logic [39:0] pp_pick;
    bit          wild;
    logic [15:0] d;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Registers at reset: zero focal reciprocal, every point collapses to the axis.
    add_pixel(20'd0, 20'd0, D_MAX);
    add_pixel(PX_MAX, PX_MAX, D_MAX);
    add_pixel(20'h12345, 20'hABCDE, 16'd1000);
    add_pixel(PX_MAX, 20'd0, 16'd0);
    wait_drained();

    // Typical VGA-ish camera with mild barrel distortion.
    load_camera({20'd61440, 20'd82048}, 40'd7158278, 40'd7040930,
                -40'sd314573, 40'd104858, -40'sd10486, 40'd1049, -40'sd524);
    add_pixel(20'd0, 20'd0, 16'd0);
    add_pixel(PX_MAX, PX_MAX, D_MAX);
    add_pixel(20'd82048, 20'd61440, 16'd1000);           // on the principal point
    add_pixel(20'd0, PX_MAX, D_MAX);
    add_pixel(PX_MAX, 20'd0, 16'd1);
    add_pixel(20'd163584, 20'd122624, 16'd5000);         // image corner
    add_pixel(20'd460800, 20'd20, 16'd3000);             // well outside the image
    add_pixel(20'd82049, 20'd61439, D_MAX);              // one fraction step off center
    add_pixel(20'hAAAAA, 20'h55555, 16'hAAAA);
    add_pixel(20'h55555, 20'hAAAAA, 16'h5555);
    wait_drained();

    // Largest focal reciprocals, strongest positive radial, most negative tangential:
    // drives the normalized clamp and the output clamp.
    load_camera(40'd0, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
                40'h7FFFFF, 40'h7FFFFF, 40'h7FFFFF, 40'h800000, 40'h800000);
    add_pixel(20'd0, 20'd0, D_MAX);
    add_pixel(20'd1, 20'd1, D_MAX);
    add_pixel(PX_MAX, PX_MAX, D_MAX);
    add_pixel(PX_MAX, 20'd0, 16'd1);
    add_pixel(20'd8, 20'd0, D_MAX);
    wait_drained();

    // Principal point at its maximum so offsets go negative; opposite coefficient signs.
    load_camera(40'hFF_FFFF_FFFF, 40'd4294967, 40'hFF_FFFF_FFFF,
                40'hFFFF800000, 40'hFFFF800000, 40'hFFFF800000, 40'h7FFFFF, 40'h7FFFFF);
    add_pixel(20'd0, 20'd0, D_MAX);
    add_pixel(PX_MAX, PX_MAX, D_MAX);
    add_pixel(20'd0, PX_MAX, 16'h8000);
    add_pixel(20'h80000, 20'h80000, 16'h1234);
    add_pixel(20'd0, 20'd0, 16'd0);
    wait_drained();

    // Random settings: mostly plausible cameras, every fourth one fully random.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wild = (ph % 4 == 3);
      if (wild) begin
        pp_pick = 40'({$urandom, $urandom});
      end else begin
        pp_pick = {20'($urandom_range(0, 1080 * 256)), 20'($urandom_range(0, 1920 * 256))};
      end
      if ($urandom_range(0, 7) == 0) pp_pick = ($urandom_range(0, 1) != 0) ? '1 : '0;
      load_camera(pp_pick, pick_focal(wild), pick_focal(wild),
                  pick_coeff(wild ? 8388607 : 524288), pick_coeff(wild ? 8388607 : 262144),
                  pick_coeff(wild ? 8388607 : 104858), pick_coeff(wild ? 8388607 : 10486),
                  pick_coeff(wild ? 8388607 : 10486));
      repeat (ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0:          d = '0;
          1:          d = D_MAX;
          2, 3, 4, 5: d = 16'($urandom);
          default:    d = 16'($urandom_range(200, 10000));
        endcase
        add_pixel(pick_coord(cam_pp[19:0], 1920 * 256), pick_coord(cam_pp[39:20], 1080 * 256), d);
      end
      wait_drained();
    end

    // Let any stray result show up before judging.
    repeat (STAGES + 4) @(posedge clk);
    $display("Run covered %0d pixels under %0d camera settings, %0d clipped results.",
             results_seen, settings_used, clipped_seen);
    $display("Output side held off %0d times long enough to back up the pipeline.", holds_done);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
